FILE: sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, types and codes of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int LEVEL_COUNT    = 8;
	localparam int MIN_BLOCK_LOG2 = 5;
	localparam int HEADER_BYTES   = 24;

	localparam int UNIT_W     = LEVEL_COUNT - 1;
	localparam int UNIT_COUNT = 1 << UNIT_W;
	localparam int LINK_W     = UNIT_W + 1;
	localparam int LVL_W      = 3;
	localparam int TOP_LEVEL  = LEVEL_COUNT - 1;

	typedef logic [UNIT_W-1:0] unit_t;
	typedef logic [LINK_W-1:0] link_t;
	typedef logic [LVL_W-1:0]  lvl_t;

	localparam link_t NONE_LINK = link_t'(UNIT_COUNT);
	localparam lvl_t  TOP_LVL   = lvl_t'(TOP_LEVEL);

	localparam logic ACTION_ALLOC = 1'b0;
	localparam logic ACTION_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_BLOCK = 2'd1,
		ST_BAD_SIZE = 2'd2,
		ST_BAD_FREE = 2'd3
	} status_t;

	typedef struct packed {
		logic        action;
		logic [15:0] request_bytes;
		logic [11:0] data_offset;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [11:0] result_offset;
		lvl_t        block_level;
	} rsp_t;

	// one entry per unit: free-stack link, block level, allocated flag
	typedef struct packed {
		link_t link;
		lvl_t  level;
		logic  in_use;
	} entry_t;

	typedef struct packed {
		logic   we;
		unit_t  waddr;
		entry_t wdata;
		logic   re;
		unit_t  raddr;
	} mem_req_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

endpackage

FILE: sv/bba_store.sv
// ----------------------------------------------------------------------------
// bba_store
// Per-unit entry memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bba_store (
	input  logic             clk,
	input  bba_pkg::mem_req_t mreq,
	output bba_pkg::entry_t   rdata
);
	import bba_pkg::*;

	entry_t mem [UNIT_COUNT];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem[mreq.waddr] <= mreq.wdata;
		end
		if (mreq.re) begin
			// forward a write to the same entry in the same cycle
			if (mreq.we && (mreq.waddr == mreq.raddr)) begin
				rdata_q <= mreq.wdata;
			end else begin
				rdata_q <= mem[mreq.raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/bba_seq.sv
// ----------------------------------------------------------------------------
// bba_seq
// Sequencer: level search, splits, merges and free-list walks over the store.
// ----------------------------------------------------------------------------
module bba_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bba_pkg::req_t      req,
	input  logic               rsp_free,
	output bba_pkg::seq_stat_t stat,
	output bba_pkg::rsp_t      result
);
	import bba_pkg::*;

	typedef enum logic [14:0] {
		S_CLR     = 15'b000000000000001,
		S_IDLE    = 15'b000000000000010,
		S_A_POP   = 15'b000000000000100,
		S_A_SPLIT = 15'b000000000001000,
		S_A_FIN   = 15'b000000000010000,
		S_F_CHK   = 15'b000000000100000,
		S_F_BUD   = 15'b000000001000000,
		S_P_INIT  = 15'b000000010000000,
		S_P_CHK   = 15'b000000100000000,
		S_P_NEXT  = 15'b000001000000000,
		S_P_RDU   = 15'b000010000000000,
		S_P_CLR   = 15'b000100000000000,
		S_M_PUSH  = 15'b001000000000000,
		S_DONE    = 15'b010000000000000,
		S_SPARE   = 15'b100000000000000
	} state_t;

	state_t   state_q;
	unit_t    clr_q;
	link_t    head_q [LEVEL_COUNT];
	unit_t    blk_q;
	lvl_t     lvl_q;
	lvl_t     want_q;
	link_t    cur_q;
	link_t    prev_q;
	entry_t   prev_ent_q;
	unit_t    pu_q;
	entry_t   pu_ent_q;
	logic     second_q;
	link_t    guard_q;
	rsp_t     res_q;

	mem_req_t mreq;
	entry_t   rdata;

	logic [16:0] tot;
	lvl_t        want;
	logic        size_ok;
	lvl_t        found;
	logic        found_ok;
	logic [11:0] rel;
	logic [11:0] rel_sh;
	logic        free_ok;
	unit_t       free_unit;
	lvl_t        nl_dn;
	lvl_t        nl_up;
	unit_t       bud;
	unit_t       low;
	unit_t       split_hi;
	lvl_t        flv;
	logic        walk;
	logic        hit;
	logic [11:0] alloc_off;

	bba_store u_store (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	// size to level, and first free level at or above it
	always_comb begin
		tot      = {1'b0, req.request_bytes} + 17'(HEADER_BYTES);
		want     = '0;
		size_ok  = 1'b0;
		for (int w = LEVEL_COUNT - 1; w >= 0; w--) begin
			if (32'(tot) <= (32'd1 << (w + MIN_BLOCK_LOG2))) begin
				want    = lvl_t'(w);
				size_ok = 1'b1;
			end
		end
		if (req.request_bytes == 16'd0) begin
			size_ok = 1'b0;
		end
		found    = '0;
		found_ok = 1'b0;
		for (int f = LEVEL_COUNT - 1; f >= 0; f--) begin
			if ((lvl_t'(f) >= want) && !head_q[f][UNIT_W]) begin
				found    = lvl_t'(f);
				found_ok = 1'b1;
			end
		end
	end

	// free offset decode
	always_comb begin
		rel       = req.data_offset - 12'(HEADER_BYTES);
		rel_sh    = rel >> MIN_BLOCK_LOG2;
		free_unit = rel_sh[UNIT_W-1:0];
		free_ok   = (32'(req.data_offset) >= 32'(HEADER_BYTES))
			&& (rel[MIN_BLOCK_LOG2-1:0] == '0)
			&& (32'(rel_sh) < 32'(UNIT_COUNT));
	end

	assign nl_dn     = lvl_q - lvl_t'(1);
	assign nl_up     = lvl_q + lvl_t'(1);
	assign bud       = blk_q ^ (unit_t'(1) << lvl_q);
	assign low       = (blk_q < bud) ? blk_q : bud;
	assign split_hi  = blk_q + (unit_t'(1) << nl_dn);
	assign flv       = (rdata.level > TOP_LVL) ? TOP_LVL : rdata.level;
	assign hit       = (cur_q == {1'b0, pu_q});
	assign walk      = !cur_q[UNIT_W] && !hit && (32'(guard_q) <= 32'(UNIT_COUNT));
	assign alloc_off = {blk_q, MIN_BLOCK_LOG2'(0)} + 12'(HEADER_BYTES);

	always_comb begin
		mreq = '0;
		case (state_q)
			S_CLR: begin
				mreq.we    = 1'b1;
				mreq.waddr = clr_q;
				mreq.wdata = '{link: NONE_LINK,
					level: (clr_q == '0) ? TOP_LVL : lvl_t'(0), in_use: 1'b0};
			end
			S_IDLE: begin
				if (start) begin
					if (req.action == ACTION_ALLOC) begin
						mreq.re    = size_ok && found_ok;
						mreq.raddr = head_q[found][UNIT_W-1:0];
					end else begin
						mreq.re    = free_ok;
						mreq.raddr = free_unit;
					end
				end
			end
			S_A_POP: begin
				if (lvl_q == want_q) begin
					mreq.we    = 1'b1;
					mreq.waddr = blk_q;
					mreq.wdata = '{link: NONE_LINK, level: want_q, in_use: 1'b1};
				end
			end
			S_A_SPLIT: begin
				mreq.we    = 1'b1;
				mreq.waddr = blk_q;
				mreq.wdata = '{link: head_q[nl_dn], level: nl_dn, in_use: 1'b0};
				mreq.re    = (nl_dn == want_q);
				mreq.raddr = split_hi;
			end
			S_A_FIN: begin
				mreq.we    = 1'b1;
				mreq.waddr = blk_q;
				mreq.wdata = '{link: rdata.link, level: want_q, in_use: 1'b1};
			end
			S_F_CHK: begin
				if (rdata.in_use) begin
					mreq.we    = 1'b1;
					mreq.waddr = blk_q;
					mreq.wdata = '{link: head_q[flv], level: flv, in_use: 1'b0};
					mreq.re    = (flv < TOP_LVL);
					mreq.raddr = blk_q ^ (unit_t'(1) << flv);
				end
			end
			S_P_CHK: begin
				if (walk) begin
					mreq.re    = 1'b1;
					mreq.raddr = cur_q[UNIT_W-1:0];
				end else if (hit) begin
					mreq.re    = 1'b1;
					mreq.raddr = pu_q;
				end
			end
			S_P_RDU: begin
				mreq.we = 1'b1;
				if (!prev_q[UNIT_W]) begin
					mreq.waddr = prev_q[UNIT_W-1:0];
					mreq.wdata = '{link: rdata.link, level: prev_ent_q.level,
						in_use: prev_ent_q.in_use};
				end else begin
					mreq.waddr = pu_q;
					mreq.wdata = '{link: NONE_LINK, level: rdata.level,
						in_use: rdata.in_use};
				end
			end
			S_P_CLR: begin
				mreq.we    = 1'b1;
				mreq.waddr = pu_q;
				mreq.wdata = '{link: NONE_LINK, level: pu_ent_q.level,
					in_use: pu_ent_q.in_use};
			end
			S_M_PUSH: begin
				mreq.we    = 1'b1;
				mreq.waddr = low;
				mreq.wdata = '{link: head_q[nl_up], level: nl_up, in_use: 1'b0};
				mreq.re    = (nl_up < TOP_LVL);
				mreq.raddr = low ^ (unit_t'(1) << nl_up);
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			second_q   <= 1'b0;
			blk_q      <= '0;
			lvl_q      <= '0;
			want_q     <= '0;
			cur_q      <= NONE_LINK;
			prev_q     <= NONE_LINK;
			prev_ent_q <= '0;
			pu_q       <= '0;
			pu_ent_q   <= '0;
			guard_q    <= '0;
			res_q      <= '{status: ST_OK, result_offset: '0, block_level: '0};
			for (int i = 0; i < LEVEL_COUNT; i++) begin
				head_q[i] <= (i == TOP_LEVEL) ? link_t'(0) : NONE_LINK;
			end
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + unit_t'(1);
					if (clr_q == unit_t'(UNIT_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						res_q.result_offset <= '0;
						res_q.block_level   <= '0;
						if (req.action == ACTION_ALLOC) begin
							if (!size_ok) begin
								res_q.status <= ST_BAD_SIZE;
								state_q      <= S_DONE;
							end else if (!found_ok) begin
								res_q.status <= ST_NO_BLOCK;
								state_q      <= S_DONE;
							end else begin
								res_q.status <= ST_OK;
								blk_q   <= head_q[found][UNIT_W-1:0];
								lvl_q   <= found;
								want_q  <= want;
								state_q <= S_A_POP;
							end
						end else begin
							if (!free_ok) begin
								res_q.status <= ST_BAD_FREE;
								state_q      <= S_DONE;
							end else begin
								res_q.status <= ST_OK;
								blk_q   <= free_unit;
								state_q <= S_F_CHK;
							end
						end
					end
				end
				S_A_POP: begin
					head_q[lvl_q] <= rdata.link;
					if (lvl_q == want_q) begin
						res_q.result_offset <= alloc_off;
						res_q.block_level   <= want_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_A_SPLIT;
					end
				end
				S_A_SPLIT: begin
					head_q[nl_dn] <= {1'b0, blk_q};
					blk_q <= split_hi;
					lvl_q <= nl_dn;
					if (nl_dn == want_q) begin
						state_q <= S_A_FIN;
					end
				end
				S_A_FIN: begin
					res_q.result_offset <= alloc_off;
					res_q.block_level   <= want_q;
					state_q <= S_DONE;
				end
				S_F_CHK: begin
					if (!rdata.in_use) begin
						res_q.status <= ST_BAD_FREE;
						state_q <= S_DONE;
					end else begin
						head_q[flv] <= {1'b0, blk_q};
						lvl_q <= flv;
						res_q.block_level <= flv;
						state_q <= (flv < TOP_LVL) ? S_F_BUD : S_DONE;
					end
				end
				S_F_BUD: begin
					if ((rdata.level != lvl_q) || rdata.in_use) begin
						state_q <= S_DONE;
					end else begin
						second_q <= 1'b0;
						state_q  <= S_P_INIT;
					end
				end
				S_P_INIT: begin
					pu_q    <= second_q ? blk_q : bud;
					cur_q   <= head_q[lvl_q];
					prev_q  <= NONE_LINK;
					guard_q <= '0;
					state_q <= S_P_CHK;
				end
				S_P_CHK: begin
					if (walk) begin
						state_q <= S_P_NEXT;
					end else if (hit) begin
						state_q <= S_P_RDU;
					end else begin
						// not on the list: leave the stack as it is
						second_q <= 1'b1;
						state_q  <= second_q ? S_M_PUSH : S_P_INIT;
					end
				end
				S_P_NEXT: begin
					prev_q     <= cur_q;
					prev_ent_q <= rdata;
					cur_q      <= rdata.link;
					guard_q    <= guard_q + link_t'(1);
					state_q    <= S_P_CHK;
				end
				S_P_RDU: begin
					pu_ent_q <= rdata;
					if (!prev_q[UNIT_W]) begin
						state_q <= S_P_CLR;
					end else begin
						head_q[lvl_q] <= rdata.link;
						second_q <= 1'b1;
						state_q  <= second_q ? S_M_PUSH : S_P_INIT;
					end
				end
				S_P_CLR: begin
					second_q <= 1'b1;
					state_q  <= second_q ? S_M_PUSH : S_P_INIT;
				end
				S_M_PUSH: begin
					head_q[nl_up] <= {1'b0, low};
					blk_q <= low;
					lvl_q <= nl_up;
					res_q.block_level <= nl_up;
					state_q <= (nl_up < TOP_LVL) ? S_F_BUD : S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign result    = res_q;

endmodule

FILE: sv/buddy_block_allocator_top.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Binary buddy allocator over a 4 KiB pool of 128 units of 32 bytes.
// ----------------------------------------------------------------------------
// Each request beat either allocates a block (the size includes a 24-byte
// header; the answer is the data offset and the block level) or frees one by
// its data offset, merging it with free buddies level by level. The per-unit
// block state lives in a 128-entry store with a registered read, walked by a
// single sequencer, so one request is worked at a time. After reset the store
// is cleared entry by entry, during which req_stall stays high. Each merge
// walks the level's free stack to pull the two halves off it, so its length
// is set by how deep that stack is (up to 64 entries at level 0).
// A finished response waits in the output register while the next request
// is already taken; a second finished response holds the sequencer until
// the first one drains.
// ----------------------------------------------------------------------------
module buddy_block_allocator_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bba_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bba_pkg::rsp_t rsp
);
	import bba_pkg::*;

	seq_stat_t stat;
	rsp_t      result;
	logic      rsp_free;
	logic      req_take;
	logic      rsp_valid_q;
	rsp_t      rsp_q;

	// take a request beat only while the sequencer is idle
	assign req_stall = !stat.idle;
	assign req_take  = req_valid && !req_stall;

	// the output register can take a result when empty or being drained
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	bba_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_take),
		.req      (req),
		.rsp_free (rsp_free),
		.stat     (stat),
		.result   (result)
	);

	// output register: load a finished result, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_free) begin
			rsp_valid_q <= stat.done;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_free && stat.done) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: sv/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the buddy block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input bba_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input bba_pkg::rsp_t rsp
);
	import bba_pkg::*;

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// errors carry no offset and no level
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |->
		(rsp.result_offset == '0) && (rsp.block_level == '0))
		else $error("error response with payload");

	// a taken request makes the block busy on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while still working");

	// an allocated data offset sits one header past a unit boundary
	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_OK) && (rsp.result_offset != '0) |->
		(rsp.result_offset[MIN_BLOCK_LOG2-1:0] == MIN_BLOCK_LOG2'(HEADER_BYTES)))
		else $error("misaligned data offset");

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (.*);
